@@ hw/rtl/ucrr_pkg.sv @@
// Shared types, codes and descriptor tables for the USB control request responder.
// Used by the controller, the datapath and the top level; depends on nothing.
`default_nettype none

package ucrr_pkg;

   localparam int MAX_PACKET_DEFAULT = 64;
   localparam int LEN_W              = 7;

   // Event codes on the request channel.
   localparam logic [1:0] CMD_BUS_RESET = 2'd0;
   localparam logic [1:0] CMD_SETUP     = 2'd1;
   localparam logic [1:0] CMD_IN_DONE   = 2'd2;
   localparam logic [1:0] CMD_UNUSED    = 2'd3;

   // Reply kinds on the response channel.
   localparam logic [1:0] KIND_STATUS = 2'd0;
   localparam logic [1:0] KIND_DATA   = 2'd1;
   localparam logic [1:0] KIND_ZLP    = 2'd2;

   // Standard request codes and the device-to-host standard request type.
   localparam logic [7:0] REQ_SET_ADDRESS    = 8'h05;
   localparam logic [7:0] REQ_READ_DESC      = 8'h06;
   localparam logic [7:0] REQ_SET_CONFIG     = 8'h09;
   localparam logic [7:0] TYPE_DEVICE_IN     = 8'h80;

   // Descriptor type numbers.
   localparam logic [7:0] DT_DEVICE = 8'h01;
   localparam logic [7:0] DT_CONFIG = 8'h02;
   localparam logic [7:0] DT_STRING = 8'h03;

   localparam int DEVICE_LEN = 18;
   localparam int CONFIG_LEN = 75;
   localparam int LANG_LEN   = 4;

   typedef enum logic [1:0] {
      DESC_DEVICE,
      DESC_CONFIG,
      DESC_LANG
   } desc_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_SINGLE,
      ST_STREAM
   } ucrr_state_type;

   typedef struct packed {
      logic capture;
      logic apply;
      logic load_count;
      logic emit_single;
      logic emit_byte;
   } ucrr_cmd_type;

   typedef struct packed {
      logic no_result;
      logic desc_hit;
      logic out_free;
      logic last_byte;
   } ucrr_sts_type;

   localparam logic [7:0] ROM_DEVICE [DEVICE_LEN] = '{
      8'h12, 8'h01, 8'h00, 8'h02, 8'h00, 8'h00, 8'h00, 8'h40,
      8'hC0, 8'h16, 8'h55, 8'h15, 8'h00, 8'h01, 8'h01, 8'h02,
      8'h03, 8'h01
   };

   localparam logic [7:0] ROM_CONFIG [CONFIG_LEN] = '{
      8'h09, 8'h02, 8'h43, 8'h00, 8'h02, 8'h01, 8'h00, 8'h80, 8'h32,
      8'h08, 8'h0B, 8'h00, 8'h02, 8'h02, 8'h01, 8'h00, 8'h00,
      8'h09, 8'h04, 8'h00, 8'h00, 8'h01, 8'h02, 8'h02, 8'h01, 8'h00,
      8'h05, 8'h24, 8'h00, 8'h10, 8'h01,
      8'h05, 8'h24, 8'h01, 8'h00, 8'h01,
      8'h04, 8'h24, 8'h02, 8'h02,
      8'h05, 8'h24, 8'h06, 8'h00, 8'h01,
      8'h07, 8'h05, 8'h82, 8'h02, 8'h40, 8'h00, 8'h00,
      8'h09, 8'h04, 8'h01, 8'h00, 8'h02, 8'h0A, 8'h00, 8'h00, 8'h00,
      8'h07, 8'h05, 8'h03, 8'h02, 8'h40, 8'h00, 8'h00,
      8'h07, 8'h05, 8'h83, 8'h02, 8'h40, 8'h00, 8'h00
   };

   localparam logic [7:0] ROM_LANG [LANG_LEN] = '{8'h04, 8'h03, 8'h09, 8'h04};

   function automatic logic [LEN_W-1:0] desc_size(input desc_type sel);
      logic [LEN_W-1:0] size;
      case (sel)
         DESC_DEVICE: size = LEN_W'(DEVICE_LEN);
         DESC_CONFIG: size = LEN_W'(CONFIG_LEN);
         DESC_LANG:   size = LEN_W'(LANG_LEN);
         default:     size = '0;
      endcase
      return size;
   endfunction

   function automatic logic [7:0] rom_byte(input desc_type sel, input logic [LEN_W-1:0] idx);
      logic [7:0] b;
      b = 8'h00;
      case (sel)
         DESC_DEVICE: begin
            if (idx < LEN_W'(DEVICE_LEN)) b = ROM_DEVICE[idx[4:0]];
         end
         DESC_CONFIG: begin
            if (idx < LEN_W'(CONFIG_LEN)) b = ROM_CONFIG[idx];
         end
         DESC_LANG: begin
            if (idx < LEN_W'(LANG_LEN)) b = ROM_LANG[idx[1:0]];
         end
         default: b = 8'h00;
      endcase
      return b;
   endfunction

endpackage

`default_nettype wire

@@ hw/rtl/ucrr_ctrl.sv @@
// Controller state machine of the USB control request responder.
// Depends on ucrr_pkg; drives the datapath through command and status structs.
`default_nettype none

module ucrr_ctrl import ucrr_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  ucrr_sts_type      sts,
   output ucrr_cmd_type      cmd
);

   ucrr_state_type state_ff;
   ucrr_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            if (sts.no_result) begin
               state_in = ST_IDLE;
            end else if (sts.desc_hit) begin
               state_in = ST_STREAM;
            end else begin
               state_in = ST_SINGLE;
            end
         end
         ST_SINGLE: begin
            if (sts.out_free) state_in = ST_IDLE;
         end
         ST_STREAM: begin
            if (sts.out_free && sts.last_byte) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_tready      = 1'b0;
      cmd             = '0;
      case (state_ff)
         ST_IDLE: begin
            req_tready  = 1'b1;
            cmd.capture = req_tvalid;
         end
         ST_EXEC: begin
            cmd.load_count = sts.desc_hit && !sts.no_result;
            cmd.apply      = !sts.desc_hit && !sts.no_result;
         end
         ST_SINGLE: begin
            cmd.emit_single = sts.out_free;
         end
         ST_STREAM: begin
            cmd.emit_byte = sts.out_free;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

endmodule

`default_nettype wire

@@ hw/rtl/ucrr_datapath.sv @@
// Datapath of the USB control request responder: item capture, device state,
// descriptor byte counter and the response output register. Depends on ucrr_pkg.
`default_nettype none

module ucrr_datapath import ucrr_pkg::*; #(
   parameter int MAX_PACKET = MAX_PACKET_DEFAULT
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  ucrr_cmd_type      cmd,
   output ucrr_sts_type      sts,
   input  wire logic [31:0]  req_tdata,
   input  wire logic [1:0]   req_tuser,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [23:0]       rsp_tdata,
   output logic [1:0]        rsp_tuser,
   output logic              rsp_tlast
);

   localparam int IdxW = $clog2(MAX_PACKET);

   logic [1:0]       command_ff;
   logic [7:0]       rtype_ff;
   logic [7:0]       rcode_ff;
   logic [7:0]       vlo_ff;
   logic [7:0]       vhi_ff;

   logic [6:0]       pending_address_ff;
   logic             address_pending_ff;
   logic [6:0]       applied_address_ff;
   logic             applied_enable_ff;
   logic             configured_ff;

   desc_type         sel_ff;
   logic [LEN_W-1:0] len_ff;
   logic [IdxW-1:0]  idx_ff;

   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   logic [1:0]       rsp_kind_ff;
   logic [7:0]       rsp_data_ff;
   logic [LEN_W-1:0] rsp_len_ff;
   logic             rsp_last_ff;
   logic             rsp_enable_ff;
   logic [6:0]       rsp_address_ff;
   logic             rsp_config_ff;

   desc_type         sel_dec;
   logic             type_known;
   logic             desc_req;
   logic [LEN_W-1:0] size_dec;
   logic [LEN_W-1:0] len_dec;
   logic [LEN_W-1:0] idx_ext;

   always_comb begin
      sel_dec    = DESC_DEVICE;
      type_known = 1'b1;
      case (vhi_ff)
         DT_DEVICE: sel_dec = DESC_DEVICE;
         DT_CONFIG: sel_dec = DESC_CONFIG;
         DT_STRING: sel_dec = DESC_LANG;
         default:   type_known = 1'b0;
      endcase
   end

   assign desc_req = (command_ff == CMD_SETUP) && (rcode_ff == REQ_READ_DESC)
                     && (rtype_ff == TYPE_DEVICE_IN);
   assign size_dec = desc_size(sel_dec);
   assign len_dec  = (size_dec > LEN_W'(MAX_PACKET)) ? LEN_W'(MAX_PACKET) : size_dec;
   assign idx_ext  = LEN_W'(idx_ff);

   assign sts.no_result = (command_ff == CMD_UNUSED);
   assign sts.desc_hit  = desc_req && type_known;
   assign sts.out_free  = !rsp_valid_ff || rsp_tready;
   assign sts.last_byte = ((idx_ext + LEN_W'(1)) == len_ff);

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         command_ff <= req_tuser;
         rtype_ff   <= req_tdata[7:0];
         rcode_ff   <= req_tdata[15:8];
         vlo_ff     <= req_tdata[23:16];
         vhi_ff     <= req_tdata[31:24];
      end
      if (cmd.load_count) begin
         sel_ff <= sel_dec;
         len_ff <= len_dec;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
      end else if (cmd.load_count) begin
         idx_ff <= '0;
      end else if (cmd.emit_byte) begin
         idx_ff <= idx_ff + IdxW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_address_ff <= '0;
         address_pending_ff <= 1'b0;
         applied_address_ff <= '0;
         applied_enable_ff  <= 1'b0;
         configured_ff      <= 1'b0;
      end else if (cmd.apply) begin
         case (command_ff)
            CMD_BUS_RESET: begin
               pending_address_ff <= '0;
               address_pending_ff <= 1'b0;
               applied_address_ff <= '0;
               applied_enable_ff  <= 1'b0;
               configured_ff      <= 1'b0;
            end
            CMD_IN_DONE: begin
               if (address_pending_ff) begin
                  applied_address_ff <= pending_address_ff;
                  applied_enable_ff  <= 1'b1;
                  address_pending_ff <= 1'b0;
               end
            end
            CMD_SETUP: begin
               if (rcode_ff == REQ_SET_ADDRESS) begin
                  pending_address_ff <= vlo_ff[6:0];
                  address_pending_ff <= 1'b1;
               end else if (rcode_ff == REQ_SET_CONFIG) begin
                  configured_ff <= 1'b1;
               end
            end
            default: begin
               configured_ff <= configured_ff;
            end
         endcase
      end
   end

   assign rsp_valid_in = cmd.emit_single || cmd.emit_byte || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_single || cmd.emit_byte) begin
         rsp_enable_ff  <= applied_enable_ff;
         rsp_address_ff <= applied_address_ff;
         rsp_config_ff  <= configured_ff;
      end
      if (cmd.emit_single) begin
         rsp_kind_ff <= (command_ff == CMD_SETUP) ? KIND_ZLP : KIND_STATUS;
         rsp_data_ff <= 8'h00;
         rsp_len_ff  <= '0;
         rsp_last_ff <= 1'b1;
      end else if (cmd.emit_byte) begin
         rsp_kind_ff <= KIND_DATA;
         rsp_data_ff <= rom_byte(sel_ff, idx_ext);
         rsp_len_ff  <= len_ff;
         rsp_last_ff <= sts.last_byte;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {rsp_config_ff, rsp_address_ff, rsp_enable_ff, rsp_len_ff, rsp_data_ff};

`ifndef NO_ASSERTIONS
   a_enable_from_pending: assert property (@(posedge clock) disable iff (reset)
      $rose(applied_enable_ff) |-> $past(address_pending_ff))
      else $error("address enabled without a pending address");

   a_emit_into_free_slot: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit_single || cmd.emit_byte) |-> (!rsp_valid_ff || rsp_tready))
      else $error("result written over an untaken result");

   a_non_data_is_empty: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_kind_ff != KIND_DATA)) |-> (rsp_data_ff == 8'h00)
         && (rsp_len_ff == '0) && rsp_last_ff)
      else $error("status or empty reply carries data");

   a_byte_within_length: assert property (@(posedge clock) disable iff (reset)
      cmd.emit_byte |-> (idx_ext < len_ff))
      else $error("descriptor byte index past reply length");
`endif

endmodule

`default_nettype wire

@@ hw/rtl/usb_control_request_responder_top.sv @@
// USB control endpoint standard request responder, top level.
// Joins ucrr_ctrl and ucrr_datapath; depends on ucrr_pkg.
//
// The request channel carries one control endpoint event per item: a bus
// reset, a received setup packet or a finished control IN transfer. The
// response channel returns the items that the event causes: one status or
// zero-length reply item, or one item per descriptor byte for a descriptor
// request, with tlast on the final item of the event. Every response item also
// shows the applied address, its enable bit and the configured flag.
// An event is taken only when the block is idle. It is decoded in the next
// cycle, and its first response item is written from the reply state once the
// output register is free. A descriptor of N bytes, with N at most MAX_PACKET,
// goes out one byte per cycle from the descriptor ROM while the receiver does
// not stall. The undefined event code gives no item. When the receiver stalls,
// the output register holds its item and the controller waits; the next
// request is still taken once the last item of the previous one sits in the
// output register. Reset empties the output register and clears the address,
// its enable and the configured flag.
`default_nettype none

module usb_control_request_responder_top import ucrr_pkg::*; #(
   parameter int MAX_PACKET = MAX_PACKET_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // request_type[7:0], request_code[15:8], value_low[23:16], value_high[31:24]
   input  wire logic [31:0] req_tdata,
   // command[1:0]
   input  wire logic [1:0]  req_tuser,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // data_byte[7:0], packet_length[14:8], address_enabled[15],
   // active_address[22:16], is_configured[23]
   output logic [23:0]      rsp_tdata,
   // reply_kind[1:0]
   output logic [1:0]       rsp_tuser,
   output logic             rsp_tlast
);

   ucrr_cmd_type dp_cmd;
   ucrr_sts_type dp_sts;

   ucrr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (dp_sts),
      .cmd        (dp_cmd)
   );

   ucrr_datapath #(
      .MAX_PACKET (MAX_PACKET)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (dp_cmd),
      .sts        (dp_sts),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

`default_nettype wire

@@ dv/usb_control_request_responder_top_tb.sv @@
// Self-checking testbench for usb_control_request_responder_top: directed and random control
// endpoint events, with every reply item checked against an in-bench prediction.
// Depends on ucrr_pkg and the RTL of usb_control_request_responder_top.

module usb_control_request_responder_top_tb;
   import ucrr_pkg::*;

   localparam int RANDOM_EVENTS = 406;
   localparam int STALL_LIMIT   = 4000;
   localparam int DRAIN_CYCLES  = 20;

   typedef struct packed {
      logic [1:0] cmd;
      logic [7:0] rtype;
      logic [7:0] rcode;
      logic [7:0] vlo;
      logic [7:0] vhi;
   } ctrl_evt_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] data;
      logic [6:0] len;
      logic       last;
      logic       en;
      logic [6:0] addr;
      logic       cfg;
   } reply_type;

   localparam logic [7:0] DEVICE_BYTES [18] = '{
      8'h12, 8'h01, 8'h00, 8'h02, 8'h00, 8'h00, 8'h00, 8'h40,
      8'hC0, 8'h16, 8'h55, 8'h15, 8'h00, 8'h01, 8'h01, 8'h02,
      8'h03, 8'h01
   };

   localparam logic [7:0] CONFIG_BYTES [75] = '{
      8'h09, 8'h02, 8'h43, 8'h00, 8'h02, 8'h01, 8'h00, 8'h80, 8'h32,
      8'h08, 8'h0B, 8'h00, 8'h02, 8'h02, 8'h01, 8'h00, 8'h00,
      8'h09, 8'h04, 8'h00, 8'h00, 8'h01, 8'h02, 8'h02, 8'h01, 8'h00,
      8'h05, 8'h24, 8'h00, 8'h10, 8'h01,
      8'h05, 8'h24, 8'h01, 8'h00, 8'h01,
      8'h04, 8'h24, 8'h02, 8'h02,
      8'h05, 8'h24, 8'h06, 8'h00, 8'h01,
      8'h07, 8'h05, 8'h82, 8'h02, 8'h40, 8'h00, 8'h00,
      8'h09, 8'h04, 8'h01, 8'h00, 8'h02, 8'h0A, 8'h00, 8'h00, 8'h00,
      8'h07, 8'h05, 8'h03, 8'h02, 8'h40, 8'h00, 8'h00,
      8'h07, 8'h05, 8'h83, 8'h02, 8'h40, 8'h00, 8'h00
   };

   localparam logic [7:0] LANG_BYTES [4] = '{8'h04, 8'h03, 8'h09, 8'h04};

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;
   logic [1:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        rsp_tlast;

   ctrl_evt_type event_q[$];
   reply_type    reply_q[$];
   ctrl_evt_type cur_evt;

   logic [6:0] pend_addr = '0;
   logic       pend_valid = 1'b0;
   logic [6:0] live_addr = '0;
   logic       live_en = 1'b0;
   logic       cfg_flag = 1'b0;

   int events_taken = 0;
   int replies_seen = 0;
   int streams_predicted = 0;
   int mismatches = 0;
   int idle_cycles = 0;

   usb_control_request_responder_top i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   function automatic logic steady();
      return events_taken >= 180 && events_taken < 260;
   endfunction

   task automatic report_mismatch(string field, int got, int want);
      if (mismatches < 40) begin
         $display("mismatch at reply %0d: %s got 0x%0h, expected 0x%0h",
                  replies_seen, field, got, want);
      end
      mismatches++;
   endtask

   function automatic void push_reply(logic [1:0] kind, logic [7:0] data, logic [6:0] len,
                                      logic last);
      reply_type r;
      r.kind = kind;
      r.data = data;
      r.len  = len;
      r.last = last;
      r.en   = live_en;
      r.addr = live_addr;
      r.cfg  = cfg_flag;
      reply_q.push_back(r);
   endfunction

   function automatic void stream_descriptor(logic [7:0] dtype);
      int size;
      int n;
      logic [7:0] b;
      size = (dtype == DT_DEVICE) ? 18 : (dtype == DT_CONFIG) ? 75 : 4;
      n = (size > MAX_PACKET_DEFAULT) ? MAX_PACKET_DEFAULT : size;
      for (int i = 0; i < n; i++) begin
         if (dtype == DT_DEVICE) b = DEVICE_BYTES[i];
         else if (dtype == DT_CONFIG) b = CONFIG_BYTES[i];
         else b = LANG_BYTES[i];
         push_reply(KIND_DATA, b, 7'(n), i == n - 1);
      end
      streams_predicted++;
   endfunction

   function automatic void predict_replies(ctrl_evt_type e);
      case (e.cmd)
         CMD_BUS_RESET: begin
            pend_addr  = '0;
            pend_valid = 1'b0;
            live_addr  = '0;
            live_en    = 1'b0;
            cfg_flag   = 1'b0;
            push_reply(KIND_STATUS, '0, '0, 1'b1);
         end
         CMD_IN_DONE: begin
            if (pend_valid) begin
               live_addr  = pend_addr;
               live_en    = 1'b1;
               pend_valid = 1'b0;
            end
            push_reply(KIND_STATUS, '0, '0, 1'b1);
         end
         CMD_SETUP: begin
            if (e.rcode == REQ_SET_ADDRESS) begin
               pend_addr  = e.vlo[6:0];
               pend_valid = 1'b1;
               push_reply(KIND_ZLP, '0, '0, 1'b1);
            end else if (e.rcode == REQ_READ_DESC && e.rtype == TYPE_DEVICE_IN &&
                         (e.vhi == DT_DEVICE || e.vhi == DT_CONFIG || e.vhi == DT_STRING)) begin
               stream_descriptor(e.vhi);
            end else begin
               if (e.rcode == REQ_SET_CONFIG) cfg_flag = 1'b1;
               push_reply(KIND_ZLP, '0, '0, 1'b1);
            end
         end
         default: ;
      endcase
   endfunction

   function automatic void add_event(logic [1:0] cmd, logic [7:0] rtype, logic [7:0] rcode,
                                     logic [7:0] vlo, logic [7:0] vhi);
      ctrl_evt_type e;
      e.cmd   = cmd;
      e.rtype = rtype;
      e.rcode = rcode;
      e.vlo   = vlo;
      e.vhi   = vhi;
      event_q.push_back(e);
   endfunction

   function automatic ctrl_evt_type random_event();
      ctrl_evt_type e;
      int pick;
      e.cmd   = CMD_SETUP;
      e.rtype = 8'($urandom_range(255));
      e.rcode = 8'($urandom_range(255));
      e.vlo   = 8'($urandom_range(255));
      e.vhi   = 8'($urandom_range(255));
      pick = $urandom_range(99);
      if (pick < 8) begin
         e.cmd = CMD_BUS_RESET;
      end else if (pick < 30) begin
         e.cmd = CMD_IN_DONE;
      end else if (pick < 34) begin
         e.cmd = CMD_UNUSED;
      end else if (pick < 52) begin
         e.rcode = REQ_SET_ADDRESS;
      end else if (pick < 74) begin
         e.rcode = REQ_READ_DESC;
         e.rtype = TYPE_DEVICE_IN;
         if ($urandom_range(7) != 0) e.vhi = 8'($urandom_range(1, 3));
      end else if (pick < 82) begin
         e.rcode = REQ_SET_CONFIG;
      end else if (pick < 88) begin
         e.rcode = REQ_READ_DESC;
      end
      return e;
   endfunction

   always @(posedge clock) begin : drive
      logic load;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         load = !req_tvalid || req_tready;
         if (req_tvalid && req_tready) begin
            predict_replies(cur_evt);
            events_taken++;
         end
         if (load) begin
            if (event_q.size() != 0 && (steady() || $urandom_range(99) >= 17)) begin
               cur_evt = event_q.pop_front();
               req_tvalid <= 1'b1;
               req_tuser  <= cur_evt.cmd;
               req_tdata  <= {cur_evt.vhi, cur_evt.vlo, cur_evt.rcode, cur_evt.rtype};
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : watch
      reply_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (reply_q.size() == 0) begin
               report_mismatch("unexpected item, data", int'(rsp_tdata), 0);
            end else begin
               want = reply_q.pop_front();
               if (rsp_tuser != want.kind)
                  report_mismatch("reply_kind", int'(rsp_tuser), int'(want.kind));
               if (rsp_tdata[7:0] != want.data)
                  report_mismatch("data_byte", int'(rsp_tdata[7:0]), int'(want.data));
               if (rsp_tdata[14:8] != want.len)
                  report_mismatch("packet_length", int'(rsp_tdata[14:8]), int'(want.len));
               if (rsp_tlast != want.last)
                  report_mismatch("last_of_run", int'(rsp_tlast), int'(want.last));
               if (rsp_tdata[15] != want.en)
                  report_mismatch("address_enabled", int'(rsp_tdata[15]), int'(want.en));
               if (rsp_tdata[22:16] != want.addr)
                  report_mismatch("active_address", int'(rsp_tdata[22:16]), int'(want.addr));
               if (rsp_tdata[23] != want.cfg)
                  report_mismatch("is_configured", int'(rsp_tdata[23]), int'(want.cfg));
            end
            replies_seen++;
         end
         rsp_tready <= steady() || $urandom_range(99) >= 17;
      end
   end

   always @(posedge clock) begin : stall_watch
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("FAIL usb_control_request_responder_top");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin : stimulus
      int sent;
      ctrl_evt_type e;
      sent = 0;
      // Directed part: resets, address handling, every descriptor and the odd requests.
      add_event(CMD_BUS_RESET, 8'h00, 8'h00, 8'h00, 8'h00);
      add_event(CMD_IN_DONE, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
      add_event(CMD_SETUP, 8'h00, REQ_SET_ADDRESS, 8'hFF, 8'h00);
      add_event(CMD_IN_DONE, 8'h00, 8'h00, 8'h00, 8'h00);
      add_event(CMD_SETUP, TYPE_DEVICE_IN, REQ_READ_DESC, 8'h00, DT_DEVICE);
      add_event(CMD_SETUP, TYPE_DEVICE_IN, REQ_READ_DESC, 8'h00, DT_CONFIG);
      add_event(CMD_SETUP, TYPE_DEVICE_IN, REQ_READ_DESC, 8'hFF, DT_STRING);
      add_event(CMD_SETUP, TYPE_DEVICE_IN, REQ_READ_DESC, 8'h00, 8'h00);
      add_event(CMD_SETUP, TYPE_DEVICE_IN, REQ_READ_DESC, 8'h00, 8'hFF);
      add_event(CMD_SETUP, 8'h81, REQ_READ_DESC, 8'h00, DT_DEVICE);
      add_event(CMD_SETUP, 8'h00, REQ_READ_DESC, 8'h00, DT_CONFIG);
      add_event(CMD_SETUP, REQ_READ_DESC, TYPE_DEVICE_IN, 8'h00, DT_DEVICE);
      add_event(CMD_SETUP, 8'hFF, REQ_SET_CONFIG, 8'hFF, 8'hFF);
      add_event(CMD_UNUSED, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
      add_event(CMD_SETUP, 8'h00, REQ_SET_ADDRESS, 8'h00, 8'h00);
      add_event(CMD_IN_DONE, 8'h00, 8'h00, 8'h00, 8'h00);
      add_event(CMD_SETUP, 8'hFF, REQ_SET_ADDRESS, 8'h2A, 8'hFF);
      add_event(CMD_BUS_RESET, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
      add_event(CMD_IN_DONE, 8'h00, 8'h00, 8'h00, 8'h00);
      add_event(CMD_SETUP, 8'h00, REQ_SET_ADDRESS, 8'h80, 8'h00);
      add_event(CMD_IN_DONE, 8'h00, 8'h00, 8'h00, 8'h00);
      add_event(CMD_SETUP, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
      add_event(CMD_SETUP, 8'h00, 8'h00, 8'h00, 8'h00);
      add_event(CMD_UNUSED, 8'h00, 8'h00, 8'h00, 8'h00);
      while (sent < RANDOM_EVENTS) begin
         e = random_event();
         event_q.push_back(e);
         sent++;
      end

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      while (event_q.size() != 0 || req_tvalid) @(posedge clock);
      while (reply_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d control events (bus resets, setup requests, IN completions",
               events_taken);
      $display("and undefined codes), %0d reply items, %0d descriptor streams, %0d mismatches",
               replies_seen, streams_predicted, mismatches);
      if (mismatches == 0) begin
         $display("PASS usb_control_request_responder_top");
      end else begin
         $display("FAIL usb_control_request_responder_top");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
hw/rtl/ucrr_pkg.sv
hw/rtl/ucrr_ctrl.sv
hw/rtl/ucrr_datapath.sv
hw/rtl/usb_control_request_responder_top.sv
dv/usb_control_request_responder_top_tb.sv
